>>> hw/rtl/chm_pkg.sv
// Shared types and constants for the chained hash map.
package chm_pkg;
    localparam int BUCKETS_DEF  = 16;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture request, restart bucket hashing
        logic hash;       // advance bucket hashing by one phase
        logic head;       // start walk at bucket head
        logic step;       // follow link of current slot
        logic do_insert;
        logic do_delete;
        logic do_result;  // latch result with given status
        status_t res_status;
        logic res_value;  // drive stored value onto result
    } chm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        cmd_t    cmd;
        logic    hashed;  // bucket index ready
        logic    at_end;  // current pointer is not a valid slot or walk exhausted
        logic    hit;     // current slot used and key matches
        logic    full;
        logic    free_ok; // a free slot exists
    } chm_stat_t;
endpackage

>>> hw/rtl/chm_if.sv
// Valid/ready channel interfaces for requests and results.
interface chm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    modport source (output valid, cmd, key, value, input ready);
    modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface chm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] value_out;
    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface

>>> hw/rtl/chm_ram.sv
// Generic single-port-write, registered-read RAM.
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

>>> hw/rtl/chm_datapath.sv
// Datapath: request registers, chain pointer, entry stores and result register.
module chm_datapath #(
    parameter int BUCKETS  = 16,
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          req_cmd,
    input  logic [31:0]         req_key,
    input  logic [31:0]         req_value,
    input  chm_pkg::chm_cmd_t   ctl,
    output chm_pkg::chm_stat_t  stat,
    output logic [1:0]          res_status,
    output logic [31:0]         res_value
);
    import chm_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    // key % BUCKETS: quotient = key * ceil(2^SH / BUCKETS) >> SH, exact for
    // 32-bit keys; the 33-bit reciprocal is applied in two halves.
    localparam int LB = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
    localparam int SH = 32 + LB;
    localparam logic [63:0] RECIP_W = ((64'd1 << SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS);
    localparam logic [32:0] RECIP = RECIP_W[32:0];

    logic [1:0]  cmd_reg;
    logic [31:0] key_reg, value_reg;
    logic [PW-1:0] ptr_reg, prev_reg;
    logic [PW-1:0] steps_reg;
    logic [PW-1:0] head_reg [BUCKETS];
    logic [PW-1:0] link_reg [CAPACITY];
    logic [CAPACITY-1:0] used_reg;
    logic [PW-1:0] count_reg;
    logic [1:0]  status_reg;
    logic [31:0] vout_reg;
    logic [1:0]  hph_reg;
    logic [64:0] prod_reg;
    logic [BW-1:0] bkt_reg;

    logic [48:0] mul_lo;
    logic [47:0] mul_hi;
    logic [31:0] quo, rem;
    logic [SW-1:0] ptr_idx, prev_idx, free_idx;
    logic ptr_valid, free_found;
    logic [31:0] key_rd, val_rd;

    assign mul_lo = 49'(key_reg) * 49'(RECIP[16:0]);
    assign mul_hi = 48'(key_reg) * 48'(RECIP[32:17]);
    assign quo    = 32'(prod_reg >> SH);
    assign rem    = key_reg - quo * 32'(BUCKETS);

    assign ptr_valid = ptr_reg < NIL;
    assign ptr_idx   = SW'(ptr_reg);
    assign prev_idx  = SW'(prev_reg);

    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx   = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    // Key and value stores read at the pointer; read data is valid in the cycle
    // after the pointer settles (the controller waits in S_WAIT).
    chm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
        .clk(clk), .we(ctl.do_insert), .waddr(free_idx), .wdata(key_reg),
        .raddr(ptr_idx), .rdata(key_rd));
    chm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
        .clk(clk), .we(ctl.do_insert), .waddr(free_idx), .wdata(value_reg),
        .raddr(ptr_idx), .rdata(val_rd));

    assign stat.cmd     = cmd_t'(cmd_reg);
    assign stat.hashed  = (hph_reg == 2'd3);
    assign stat.at_end  = !ptr_valid || (steps_reg >= NIL);
    assign stat.hit     = ptr_valid && used_reg[ptr_idx] && (key_rd == key_reg);
    assign stat.full    = count_reg >= NIL;
    assign stat.free_ok = free_found;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= req_cmd;
            key_reg   <= req_key;
            value_reg <= req_value;
            hph_reg   <= '0;
        end
        if (ctl.hash)
        begin
            case (hph_reg)
                2'd0:    prod_reg <= 65'(mul_lo);
                2'd1:    prod_reg <= prod_reg + {mul_hi, 17'd0};
                default: bkt_reg  <= BW'(rem);
            endcase
            hph_reg <= hph_reg + 2'd1;
        end
        if (ctl.do_result)
        begin
            status_reg <= ctl.res_status;
            vout_reg   <= ctl.res_value ? val_rd : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= NIL;
            prev_reg  <= NIL;
            steps_reg <= '0;
            used_reg  <= '0;
            count_reg <= '0;
            for (int b = 0; b < BUCKETS; b++)
                head_reg[b] <= NIL;
            for (int s = 0; s < CAPACITY; s++)
                link_reg[s] <= NIL;
        end
        else
        begin
            if (ctl.head)
            begin
                ptr_reg   <= head_reg[bkt_reg];
                prev_reg  <= NIL;
                steps_reg <= '0;
            end
            else if (ctl.step)
            begin
                prev_reg  <= ptr_reg;
                ptr_reg   <= link_reg[ptr_idx];
                steps_reg <= steps_reg + 1'b1;
            end
            if (ctl.do_insert)
            begin
                link_reg[free_idx] <= head_reg[bkt_reg];
                head_reg[bkt_reg]  <= PW'(free_idx);
                used_reg[free_idx] <= 1'b1;
                count_reg          <= count_reg + 1'b1;
            end
            if (ctl.do_delete)
            begin
                if (prev_reg == NIL)
                    head_reg[bkt_reg] <= link_reg[ptr_idx];
                else
                    link_reg[prev_idx] <= link_reg[ptr_idx];
                used_reg[ptr_idx] <= 1'b0;
                link_reg[ptr_idx] <= NIL;
                if (count_reg != '0)
                    count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign res_status = status_reg;
    assign res_value  = vout_reg;
endmodule

>>> hw/rtl/chm_ctrl.sv
// Controller: request handshake, chain walk sequencing, result handshake.
module chm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  chm_pkg::chm_stat_t  stat,
    output chm_pkg::chm_cmd_t   ctl
);
    import chm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,  // bucket index, then head read
        S_WAIT  = 5'b00100,  // RAM read of current slot in flight
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    // New request only once the previous result has been taken or is leaving.
    assign in_ready  = (state_reg == S_IDLE) && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ctl         = '0;
        ctl.res_status = ST_NOT_FOUND;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (stat.hashed)
                begin
                    ctl.head   = 1'b1;
                    state_next = S_WAIT;
                end
                else
                    ctl.hash = 1'b1;
            end
            S_WAIT:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (!stat.at_end && !stat.hit)
                begin
                    ctl.step   = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next    = S_DONE;
                    ctl.do_result = 1'b1;
                    case (stat.cmd)
                        CMD_INSERT:
                        begin
                            if (!stat.at_end && stat.hit)
                                ctl.res_status = ST_DUPLICATE;
                            else if (stat.full || !stat.free_ok)
                                ctl.res_status = ST_FULL;
                            else
                            begin
                                ctl.res_status = ST_OK;
                                ctl.do_insert  = 1'b1;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (!stat.at_end && stat.hit)
                            begin
                                ctl.res_status = ST_OK;
                                ctl.res_value  = 1'b1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (!stat.at_end && stat.hit)
                            begin
                                ctl.res_status = ST_OK;
                                ctl.do_delete  = 1'b1;
                            end
                        end
                        default: ctl.res_status = ST_NOT_FOUND;
                    endcase
                end
            end
            S_DONE:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

>>> hw/rtl/chained_hash_map_unit.sv
// Chained hash map top level: request and result channels around ctrl and datapath.
// Usage:
//   req channel (sink): cmd 0 insert, 1 find, 2 delete; key; value (insert only).
//   rsp channel (source): status 0 ok, 1 duplicate, 2 full, 3 not found;
//   value_out holds the stored word after a successful find, else zero.
//   One result beat per request beat, in order.
// Sequence: the bucket index is formed by a reciprocal multiply in two halves,
//   then the remainder, then the head read; the chain is then walked one slot
//   at a time (slot RAM read, then compare) until a hit or its end.
// Requests: one at a time; the next request beat is taken at the earliest in
//   the cycle the result goes valid, and only if that result is taken in that same cycle.
// Reset: rst_n clears all chains, slot-used flags and the entry count at once;
//   no clearing pass. Key and value stores are not reset.
// Stall: a result waits in its output register until taken; a new request
//   is not accepted while that register is full and not being drained.
module chained_hash_map_unit #(
    parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
    parameter int CAPACITY = chm_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    chm_req_if.sink     req,
    chm_rsp_if.source   rsp
);
    import chm_pkg::*;

    chm_cmd_t  ctl;
    chm_stat_t stat;

    chm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .stat(stat), .ctl(ctl));

    chm_datapath #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .req_cmd(req.cmd), .req_key(req.key), .req_value(req.value),
        .ctl(ctl), .stat(stat),
        .res_status(rsp.status), .res_value(rsp.value_out));

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.do_insert && ctl.do_delete))
        else $error("insert and delete in same cycle");
    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_value |-> (ctl.res_status == ST_OK))
        else $error("value returned with non-ok status");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> !req.ready)
        else $error("request accepted while busy");
endmodule

>>> verif/tb.sv
// Self-checking testbench for the chained hash map unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import chm_pkg::*;

    localparam int NBKT = BUCKETS_DEF;
    localparam int NCAP = CAPACITY_DEF;
    localparam int NIL = NCAP;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM = 1900;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] key;
        logic [31:0] value;
        bit          typed;
        status_t     st;
        logic [31:0] vout;
    } stim_row_t;

    typedef struct {
        status_t     st;
        logic [31:0] vout;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    chm_req_if req();
    chm_rsp_if rsp();

    chained_hash_map_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #1 clk = ~clk;

    // Shadow copy of the map.
    int          head_q[NBKT];
    logic [31:0] slot_key[NCAP];
    logic [31:0] slot_val[NCAP];
    int          slot_next[NCAP];
    bit          slot_busy[NCAP];
    int          n_used;

    answer_t     answers_due[$];
    logic [31:0] live_keys[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_rsp = 1'b0;
    bit          stim_done = 1'b0;

    stim_row_t directed[$];

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s at %0t", what, $time);
    endtask

    function automatic void map_clear();
        for (int i = 0; i < NBKT; i++)
            head_q[i] = NIL;
        for (int i = 0; i < NCAP; i++)
        begin
            slot_next[i] = NIL;
            slot_busy[i] = 1'b0;
            slot_key[i] = '0;
            slot_val[i] = '0;
        end
        n_used = 0;
    endfunction

    function automatic answer_t map_apply(cmd_t c, logic [31:0] k, logic [31:0] v);
        answer_t a;
        int b;
        int p;
        int prev;
        int hit;
        int s;
        b = k % NBKT;
        a.st = ST_NOT_FOUND;
        a.vout = '0;
        hit = NIL;
        prev = NIL;
        p = head_q[b];
        for (int n = 0; n < NCAP && p < NCAP; n++)
        begin
            if (slot_busy[p] && slot_key[p] == k)
            begin
                hit = p;
                break;
            end
            prev = p;
            p = slot_next[p];
        end
        if (hit == NIL)
            prev = NIL;
        case (c)
            CMD_INSERT:
            begin
                if (hit != NIL)
                    a.st = ST_DUPLICATE;
                else if (n_used >= NCAP)
                    a.st = ST_FULL;
                else
                begin
                    s = 0;
                    while (s < NCAP && slot_busy[s])
                        s++;
                    slot_key[s] = k;
                    slot_val[s] = v;
                    slot_next[s] = head_q[b];
                    slot_busy[s] = 1'b1;
                    head_q[b] = s;
                    n_used++;
                    a.st = ST_OK;
                end
            end
            CMD_FIND:
            begin
                if (hit != NIL)
                begin
                    a.st = ST_OK;
                    a.vout = slot_val[hit];
                end
            end
            CMD_DELETE:
            begin
                if (hit != NIL)
                begin
                    if (prev == NIL)
                        head_q[b] = slot_next[hit];
                    else
                        slot_next[prev] = slot_next[hit];
                    slot_busy[hit] = 1'b0;
                    slot_next[hit] = NIL;
                    if (n_used > 0)
                        n_used--;
                    a.st = ST_OK;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic void add_row(cmd_t c, logic [31:0] k, logic [31:0] v,
                                    bit t = 1'b0, status_t s = ST_OK,
                                    logic [31:0] o = '0);
        stim_row_t r;
        r.cmd = c;
        r.key = k;
        r.value = v;
        r.typed = t;
        r.st = s;
        r.vout = o;
        directed.push_back(r);
    endfunction

    // Drive one beat; the predictor runs when it is accepted.
    task automatic send_beat(cmd_t c, logic [31:0] k, logic [31:0] v,
                             bit t, status_t s, logic [31:0] o);
        answer_t a;
        req.valid <= 1'b1;
        req.cmd <= c;
        req.key <= k;
        req.value <= v;
        do
            @(posedge clk);
        while (!req.ready);
        a = map_apply(c, k, v);
        if (t && (a.st !== s || a.vout !== o))
            report($sformatf("directed row expects %0d/%h, predictor %0d/%h",
                             s, o, a.st, a.vout));
        if (t)
        begin
            a.st = s;
            a.vout = o;
        end
        answers_due.push_back(a);
    endtask

    task automatic pause_sender();
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && live_keys.size() != 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if (r < 80)
            return {4'($urandom_range(0, 3)), 28'd0} | 32'($urandom_range(0, 40));
        return $urandom();
    endfunction

    // Stimulus.
    initial
    begin
        int        burst;
        cmd_t      c;
        logic [31:0] k;
        int        r;
        req.valid = 1'b0;
        req.cmd = CMD_NONE;
        req.key = '0;
        req.value = '0;
        map_clear();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(CMD_FIND, 32'd0, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0);
        add_row(CMD_DELETE, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0);
        add_row(CMD_NONE, 32'd5, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 32'd0);
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'd0);
        add_row(CMD_INSERT, 32'hFFFF_FFFF, 32'd1, 1'b1, ST_DUPLICATE, 32'd0);
        add_row(CMD_FIND, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_OK, 32'hFFFF_FFFF);
        // One long chain in bucket 0 fills the rest of the map.
        for (int i = 0; i < NCAP - 1; i++)
            add_row(CMD_INSERT, 32'(i * NBKT), 32'hA000_0000 + i);
        add_row(CMD_INSERT, 32'd7, 32'd0, 1'b1, ST_FULL, 32'd0);
        add_row(CMD_INSERT, 32'd0, 32'd0, 1'b1, ST_DUPLICATE, 32'd0);
        add_row(CMD_DELETE, 32'(7 * NBKT), 32'd0, 1'b1, ST_OK, 32'd0);
        add_row(CMD_FIND, 32'(14 * NBKT), 32'd0);
        add_row(CMD_NONE, 32'(14 * NBKT), 32'd0, 1'b1, ST_NOT_FOUND, 32'd0);
        add_row(CMD_INSERT, 32'h8000_0010, 32'h5555_AAAA);
        add_row(CMD_DELETE, 32'd0, 32'd0, 1'b1, ST_OK, 32'd0);

        foreach (directed[i])
            send_beat(directed[i].cmd, directed[i].key, directed[i].value,
                      directed[i].typed, directed[i].st, directed[i].vout);
        drain();
        // Empty the map so the random part starts fresh.
        for (int s = 0; s < NCAP; s++)
            if (slot_busy[s])
                send_beat(CMD_DELETE, slot_key[s], 32'd0, 1'b0, ST_OK, '0);
        drain();

        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(1, 30);
            for (int j = 0; j < burst && n < N_RANDOM; j++, n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    c = CMD_INSERT;
                else if (r < 75)
                    c = CMD_FIND;
                else if (r < 97)
                    c = CMD_DELETE;
                else
                    c = CMD_NONE;
                k = pick_key();
                send_beat(c, k, $urandom(), 1'b0, ST_OK, '0);
                live_keys.delete();
                for (int s = 0; s < NCAP; s++)
                    if (slot_busy[s])
                        live_keys.push_back(slot_key[s]);
            end
            if ($urandom_range(0, 19) == 0)
                drain();
            else if ($urandom_range(0, 1) == 0)
                pause_sender();
        end
        drain();
        repeat (2 * NCAP + 10)
            @(posedge clk);
        stim_done = 1'b1;
    end

    // Receiver: random stalls plus one long hold-off early on.
    initial
    begin
        rsp.ready = 1'b0;
        wait (rst_n);
        repeat (40)
            @(posedge clk);
        hold_rsp = 1'b1;
        repeat (300)
            @(posedge clk);
        hold_rsp = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_rsp)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($time / 200) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // Checker and watchdog.
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                    report("result beat with nothing pending");
                else
                begin
                    a = answers_due.pop_front();
                    if (rsp.status !== a.st)
                        report($sformatf("status %0d, want %0d", rsp.status, a.st));
                    if (rsp.value_out !== a.vout)
                        report($sformatf("value_out %h, want %h", rsp.value_out, a.vout));
                end
            end
        end
    end

    initial
    begin
        wait (stim_done || idle_cycles >= IDLE_LIMIT);
        if (!stim_done)
        begin
            $display("status: fail");
        end
        else if (errors == 0 && answers_due.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> chained_hash_map_unit.f
hw/rtl/chm_pkg.sv
hw/rtl/chm_if.sv
hw/rtl/chm_ram.sv
hw/rtl/chm_datapath.sv
hw/rtl/chm_ctrl.sv
hw/rtl/chained_hash_map_unit.sv
verif/tb.sv
